// ===== src/esc_pkg.sv =====
// shared types and constants for the elevator scan controller
package esc_pkg;

   // fixed field widths
   localparam int FLOOR_W  = 4;
   localparam int TICK_W   = 16;
   localparam int COUNT_W  = 32;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // register reset values
   localparam logic [TICK_W-1:0] MOVE_TICKS_RESET = 16'd3000;
   localparam logic [TICK_W-1:0] DOOR_TICKS_RESET = 16'd4000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOVE_TICKS = 1'b0,
      CSR_DOOR_TICKS = 1'b1
   } csr_index_type;

   // item kind on the request channel
   typedef enum logic {
      FUNC_CALL = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   // call kind
   typedef enum logic [1:0] {
      KIND_CAR     = 2'd0,
      KIND_HALL_UP = 2'd1,
      KIND_HALL_DN = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   // status of a result beat
   typedef enum logic [1:0] {
      STATUS_TICK   = 2'd0,
      STATUS_ACCEPT = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   // event reported with a result beat
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_OPEN   = 3'd1,
      EV_CLOSE  = 3'd2,
      EV_MOVE   = 3'd3,
      EV_ARRIVE = 3'd4
   } event_type;

   // travel direction, two's complement
   typedef enum logic [1:0] {
      DIR_HOLD = 2'b00,
      DIR_UP   = 2'b01,
      DIR_DN   = 2'b11
   } dir_type;

   // car state apart from the call bitmaps
   typedef struct packed {
      logic [FLOOR_W-1:0] cur_floor;
      dir_type            dir;
      logic               door;
      logic               moving;
      logic [FLOOR_W-1:0] target_floor;
      logic [TICK_W-1:0]  countdown;
      logic [COUNT_W-1:0] serve_total;
   } car_state_type;

   // result tdata fields, lowest field in the lowest bits
   typedef struct packed {
      logic [FLOOR_W-1:0] pending_down;
      logic [FLOOR_W-1:0] pending_up;
      logic [FLOOR_W-1:0] pending_car;
      logic [COUNT_W-1:0] served_count;
      logic               door_ajar;
      logic [1:0]         direction;
      logic [FLOOR_W-1:0] car_floor;
      event_type          event_res;
   } rsp_data_type;

endpackage

// ===== src/esc_call_check.sv =====
// range and end-floor check of a call request, giving the bit to latch
module esc_call_check #(
   parameter int FLOORS = 4
) (
   input  logic [esc_pkg::FLOOR_W-1:0] req_floor,
   input  esc_pkg::kind_type           req_kind,
   output logic                        call_ok,
   output logic [FLOORS-1:0]           set_car,
   output logic [FLOORS-1:0]           set_up,
   output logic [FLOORS-1:0]           set_down
);

   logic [FLOORS-1:0] floor_bit;

   // one-hot bit of the requested floor
   assign floor_bit = {{(FLOORS-1){1'b0}}, 1'b1} << (req_floor - 4'd1);

   // floor range, invalid kind and the top and bottom call rules
   always_comb begin
      call_ok = (req_floor >= 4'd1) && (req_floor <= 4'(FLOORS))
                && (req_kind != esc_pkg::KIND_INVALID);
      if ((req_kind == esc_pkg::KIND_HALL_DN) && (req_floor == 4'd1)) begin
         call_ok = 1'b0;
      end
      if ((req_kind == esc_pkg::KIND_HALL_UP) && (req_floor == 4'(FLOORS))) begin
         call_ok = 1'b0;
      end
   end

   // steer the bit to its bitmap
   always_comb begin
      set_car  = '0;
      set_up   = '0;
      set_down = '0;
      if (call_ok) begin
         unique case (req_kind)
            esc_pkg::KIND_CAR:     set_car  = floor_bit;
            esc_pkg::KIND_HALL_UP: set_up   = floor_bit;
            esc_pkg::KIND_HALL_DN: set_down = floor_bit;
            default:               set_car  = '0;
         endcase
      end
   end

endmodule

// ===== src/esc_scan_step.sv =====
// next car state for one tick: timers, stop decision and collective scan
module esc_scan_step #(
   parameter int FLOORS = 4
) (
   input  esc_pkg::car_state_type       cur_state,
   input  logic [FLOORS-1:0]            car_calls,
   input  logic [FLOORS-1:0]            up_calls,
   input  logic [FLOORS-1:0]            down_calls,
   input  logic [esc_pkg::TICK_W-1:0]   move_ticks,
   input  logic [esc_pkg::TICK_W-1:0]   door_ticks,
   output esc_pkg::car_state_type       next_state,
   output logic [FLOORS-1:0]            car_next,
   output logic [FLOORS-1:0]            up_next,
   output logic [FLOORS-1:0]            down_next,
   output esc_pkg::event_type           evt_code
);

   logic [FLOORS-1:0] floor_bit;
   logic [FLOORS-1:0] all_calls;
   logic [FLOORS-1:0] above_mask;
   logic [FLOORS-1:0] below_mask;
   logic              calls_here;
   logic              calls_above;
   logic              calls_below;
   logic              must_stop;
   esc_pkg::dir_type  chosen_dir;

   // floor masks around the car
   assign floor_bit = {{(FLOORS-1){1'b0}}, 1'b1} << (cur_state.cur_floor - 4'd1);
   assign all_calls = car_calls | up_calls | down_calls;

   always_comb begin
      for (int i = 0; i < FLOORS; i++) begin
         above_mask[i] = (i >= int'(cur_state.cur_floor));
         below_mask[i] = ((i + 1) < int'(cur_state.cur_floor));
      end
   end

   assign calls_here  = |(all_calls & floor_bit);
   assign calls_above = |(all_calls & above_mask);
   assign calls_below = |(all_calls & below_mask);

   // stop at this floor for the current direction
   always_comb begin
      must_stop = 1'b0;
      unique case (cur_state.dir)
         esc_pkg::DIR_HOLD: must_stop = calls_here;
         esc_pkg::DIR_UP:   must_stop = (|(up_calls & floor_bit))
                                        || (!calls_above && (|(down_calls & floor_bit)));
         default:           must_stop = (|(down_calls & floor_bit))
                                        || (!calls_below && (|(up_calls & floor_bit)));
      endcase
      if (|(car_calls & floor_bit)) begin
         must_stop = 1'b1;
      end
   end

   // collective scan: keep going while calls lie ahead, else turn round
   always_comb begin
      chosen_dir = esc_pkg::DIR_HOLD;
      if (all_calls != '0) begin
         unique case (cur_state.dir)
            esc_pkg::DIR_HOLD: begin
               if (calls_here)       chosen_dir = esc_pkg::DIR_HOLD;
               else if (calls_above) chosen_dir = esc_pkg::DIR_UP;
               else if (calls_below) chosen_dir = esc_pkg::DIR_DN;
               else                  chosen_dir = esc_pkg::DIR_HOLD;
            end
            esc_pkg::DIR_UP: begin
               if (calls_above || calls_here) chosen_dir = esc_pkg::DIR_UP;
               else if (calls_below)          chosen_dir = esc_pkg::DIR_DN;
               else                           chosen_dir = esc_pkg::DIR_HOLD;
            end
            default: begin
               if (calls_below || calls_here) chosen_dir = esc_pkg::DIR_DN;
               else if (calls_above)          chosen_dir = esc_pkg::DIR_UP;
               else                           chosen_dir = esc_pkg::DIR_HOLD;
            end
         endcase
      end
   end

   // tick outcome
   always_comb begin
      next_state = cur_state;
      car_next   = car_calls;
      up_next    = up_calls;
      down_next  = down_calls;
      evt_code   = esc_pkg::EV_NONE;
      if (cur_state.door || cur_state.moving) begin
         // door or travel timer running
         if (cur_state.countdown > 16'd1) begin
            next_state.countdown = cur_state.countdown - 16'd1;
         end else begin
            next_state.countdown = '0;
            if (cur_state.door) begin
               next_state.door = 1'b0;
               evt_code        = esc_pkg::EV_CLOSE;
            end else begin
               next_state.moving    = 1'b0;
               next_state.cur_floor = cur_state.target_floor;
               evt_code             = esc_pkg::EV_ARRIVE;
            end
         end
      end else if (must_stop) begin
         // serve the floor
         next_state.door        = 1'b1;
         car_next               = car_calls & ~floor_bit;
         up_next                = up_calls & ~floor_bit;
         down_next              = down_calls & ~floor_bit;
         next_state.serve_total = cur_state.serve_total + 32'd1;
         next_state.countdown   = door_ticks;
         evt_code               = esc_pkg::EV_OPEN;
      end else begin
         next_state.dir = chosen_dir;
         if ((all_calls != '0) && (chosen_dir != esc_pkg::DIR_HOLD)) begin
            if ((chosen_dir == esc_pkg::DIR_UP) && (cur_state.cur_floor < 4'(FLOORS))) begin
               next_state.target_floor = cur_state.cur_floor + 4'd1;
               next_state.moving       = 1'b1;
               next_state.countdown    = move_ticks;
               evt_code                = esc_pkg::EV_MOVE;
            end else if ((chosen_dir == esc_pkg::DIR_DN)
                         && (cur_state.cur_floor > 4'd1)) begin
               next_state.target_floor = cur_state.cur_floor - 4'd1;
               next_state.moving       = 1'b1;
               next_state.countdown    = move_ticks;
               evt_code                = esc_pkg::EV_MOVE;
            end else begin
               // blocked at an end floor
               next_state.dir = esc_pkg::DIR_HOLD;
            end
         end
      end
   end

endmodule

// ===== src/elevator_scan_controller_unit.sv =====
// top level of the single-car elevator dispatcher
// Single-car elevator dispatcher with collective scan. Each request beat is either a
// call (tuser 0: floor and kind in tdata) or a one time tick (tuser 1). Calls are range
// checked and latched into the car, hall-up and hall-down bitmaps; ticks run the door
// and travel timers, open the door at floors to be served and start one-floor moves.
// Every request beat yields exactly one response beat carrying the status, the event
// and the car state after the beat. Throughput is one beat per clock while the response
// channel is not stalled: a beat is captured in an input register, then one pass through
// the call check and scan logic updates the car state and loads the response register.
// Timer registers are written through the csr port; the user must write them only while
// the block is idle, which the block itself does not enforce. A timer value of zero acts
// as one tick.
module elevator_scan_controller_unit #(
   parameter int FLOORS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_we,
   input  logic [esc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [esc_pkg::TICK_W-1:0]     csr_wdata,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [3:0] req_floor, [5:4] req_kind, [7:6] zero
   input  logic [esc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic                           req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] event_res, [6:3] car_floor, [8:7] direction, [9] door_ajar,
   // [41:10] served_count, [45:42] pending_car, [49:46] pending_up,
   // [53:50] pending_down, [55:54] zero
   output logic [esc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] req_status
   output logic [1:0]                     rsp_tuser
);

   // timer registers
   logic [esc_pkg::TICK_W-1:0] move_ticks_ff;
   logic [esc_pkg::TICK_W-1:0] door_ticks_ff;

   // input stage
   logic                          in_valid_ff;
   logic                          in_valid_in;
   esc_pkg::func_type             in_func_ff;
   logic [esc_pkg::FLOOR_W-1:0]   in_floor_ff;
   esc_pkg::kind_type             in_kind_ff;
   logic                          advance;

   // car state
   esc_pkg::car_state_type state_ff;
   esc_pkg::car_state_type state_in;
   logic [FLOORS-1:0]      car_ff;
   logic [FLOORS-1:0]      up_ff;
   logic [FLOORS-1:0]      down_ff;
   logic [FLOORS-1:0]      car_in;
   logic [FLOORS-1:0]      up_in;
   logic [FLOORS-1:0]      down_in;

   // result stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   esc_pkg::rsp_data_type  rsp_data_ff;
   esc_pkg::rsp_data_type  rsp_data_in;
   esc_pkg::status_type    rsp_status_ff;
   esc_pkg::status_type    rsp_status_in;

   // unit outputs
   logic                   call_ok;
   logic [FLOORS-1:0]      set_car;
   logic [FLOORS-1:0]      set_up;
   logic [FLOORS-1:0]      set_down;
   esc_pkg::car_state_type tick_state;
   logic [FLOORS-1:0]      tick_car;
   logic [FLOORS-1:0]      tick_up;
   logic [FLOORS-1:0]      tick_down;
   esc_pkg::event_type     tick_event;
   esc_pkg::event_type     evt_in;

   // bitmaps widened so the low four bits always exist
   logic [FLOORS+3:0]      car_wide;
   logic [FLOORS+3:0]      up_wide;
   logic [FLOORS+3:0]      down_wide;

   // handshake: the input beat moves on when the result register is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   esc_call_check #(
      .FLOORS (FLOORS)
   ) u_call_check (
      .req_floor (in_floor_ff),
      .req_kind  (in_kind_ff),
      .call_ok   (call_ok),
      .set_car   (set_car),
      .set_up    (set_up),
      .set_down  (set_down)
   );

   esc_scan_step #(
      .FLOORS (FLOORS)
   ) u_scan_step (
      .cur_state  (state_ff),
      .car_calls  (car_ff),
      .up_calls   (up_ff),
      .down_calls (down_ff),
      .move_ticks (move_ticks_ff),
      .door_ticks (door_ticks_ff),
      .next_state (tick_state),
      .car_next   (tick_car),
      .up_next    (tick_up),
      .down_next  (tick_down),
      .evt_code   (tick_event)
   );

   // pick the update for the beat in the input stage
   always_comb begin
      state_in      = state_ff;
      car_in        = car_ff;
      up_in         = up_ff;
      down_in       = down_ff;
      evt_in        = esc_pkg::EV_NONE;
      rsp_status_in = esc_pkg::STATUS_TICK;
      if (in_func_ff == esc_pkg::FUNC_TICK) begin
         state_in = tick_state;
         car_in   = tick_car;
         up_in    = tick_up;
         down_in  = tick_down;
         evt_in   = tick_event;
      end else begin
         car_in        = car_ff | set_car;
         up_in         = up_ff | set_up;
         down_in       = down_ff | set_down;
         rsp_status_in = call_ok ? esc_pkg::STATUS_ACCEPT : esc_pkg::STATUS_REJECT;
      end
   end

   // result fields from the state after the beat
   assign car_wide  = {4'b0000, car_in};
   assign up_wide   = {4'b0000, up_in};
   assign down_wide = {4'b0000, down_in};

   always_comb begin
      rsp_data_in.event_res    = evt_in;
      rsp_data_in.car_floor    = state_in.cur_floor;
      rsp_data_in.direction    = state_in.dir;
      rsp_data_in.door_ajar    = state_in.door;
      rsp_data_in.served_count = state_in.serve_total;
      rsp_data_in.pending_car  = car_wide[3:0];
      rsp_data_in.pending_up   = up_wide[3:0];
      rsp_data_in.pending_down = down_wide[3:0];
   end

   // timer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         move_ticks_ff <= esc_pkg::MOVE_TICKS_RESET;
         door_ticks_ff <= esc_pkg::DOOR_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            esc_pkg::CSR_MOVE_TICKS: move_ticks_ff <= csr_wdata;
            esc_pkg::CSR_DOOR_TICKS: door_ticks_ff <= csr_wdata;
            default:                 move_ticks_ff <= move_ticks_ff;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_func_ff  <= esc_pkg::func_type'(req_tuser);
         in_floor_ff <= req_tdata[3:0];
         in_kind_ff  <= esc_pkg::kind_type'(req_tdata[5:4]);
      end
   end

   // car state and call bitmaps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cur_floor    <= 4'd1;
         state_ff.dir          <= esc_pkg::DIR_HOLD;
         state_ff.door         <= 1'b0;
         state_ff.moving       <= 1'b0;
         state_ff.target_floor <= 4'd1;
         state_ff.countdown    <= '0;
         state_ff.serve_total  <= '0;
         car_ff                <= '0;
         up_ff                 <= '0;
         down_ff               <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         car_ff   <= car_in;
         up_ff    <= up_in;
         down_ff  <= down_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

   // door open and travel never overlap
   a_door_or_move : assert property (@(posedge clock) disable iff (reset)
      !(state_ff.door && state_ff.moving))
      else $error("door open while car moving");

   // car stays within the shaft
   a_floor_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff.cur_floor >= 4'd1) && (state_ff.cur_floor <= 4'(FLOORS)))
      else $error("car floor out of range");

   // a move always goes to a neighbouring floor
   a_target_adjacent : assert property (@(posedge clock) disable iff (reset)
      state_ff.moving |-> ((state_ff.target_floor == state_ff.cur_floor + 4'd1)
                           || (state_ff.target_floor == state_ff.cur_floor - 4'd1)))
      else $error("move target not adjacent");

   // a held input beat is never dropped
   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled beat lost");

endmodule
